[rtl/sfq_pkg.sv]
package sfq_pkg;

    // action codes
    localparam logic [2:0] ACT_ENQUEUE   = 3'd0;
    localparam logic [2:0] ACT_FLUSH     = 3'd1;
    localparam logic [2:0] ACT_EXPIRE    = 3'd2;
    localparam logic [2:0] ACT_LINK_UP   = 3'd3;
    localparam logic [2:0] ACT_LINK_DOWN = 3'd4;
    localparam logic [2:0] ACT_CLEAR     = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DROPPED   = 2'd1;
    localparam logic [1:0] ST_LINK_DOWN = 2'd2;

    // most events one flush may send
    localparam logic [6:0] SEND_CAP = 7'd64;

    typedef struct packed {
        logic [23:0] point;
        logic [15:0] source;
        logic [63:0] value;
        logic [31:0] stamp;
    } entry_t;

endpackage

[rtl/sfq_store.sv]
module sfq_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  sfq_pkg::entry_t wr_entry,
    input  logic            mk_wr_en,
    input  logic [AW-1:0]   mk_addr,
    input  logic            mk_data,
    input  logic [AW-1:0]   rd_addr,
    output sfq_pkg::entry_t rd_entry,
    output logic            rd_mark
);
    import sfq_pkg::*;

    entry_t entry_mem [DEPTH];
    logic   mark_mem  [DEPTH];

    // entry payload, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_entry;
        end
        rd_entry <= entry_mem[rd_addr];
    end

    // expired marks
    always_ff @(posedge aclk) begin
        if (mk_wr_en) begin
            mark_mem[mk_addr] <= mk_data;
        end
        rd_mark <= mark_mem[rd_addr];
    end

endmodule

[rtl/store_forward_queue_with_expiry.sv]
// enqueue, link and clear actions give their registered word in the cycle after accept
// flush: a counting walk pops entries (address phase, mark check each), then a
// send walk rereads them, sending words and skipping expired ones until the last word
// expire: address phase and age compare per held entry, store read port registered
// throughput: one action at a time, s_ready is low while a walk runs or a word waits
// reset: synchronous active-low aresetn, queue empty, link up, totals zero,
// capacity 64; store contents are not cleared
module store_forward_queue_with_expiry #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wen,
    input  logic [6:0]  cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [23:0] s_point_ident,
    input  logic [15:0] s_source_ident,
    input  logic [63:0] s_sample_value,
    input  logic [31:0] s_current_time,
    input  logic [6:0]  s_send_limit,
    input  logic [31:0] s_age_limit,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_event_valid,
    output logic [23:0] m_sent_point,
    output logic [15:0] m_sent_source,
    output logic [63:0] m_sent_value,
    output logic [31:0] m_sent_stamp,
    output logic [6:0]  m_tally,
    output logic [6:0]  m_queue_level,
    output logic        m_link_up,
    output logic [31:0] m_dropped_total,
    output logic [31:0] m_expired_total,
    output logic        m_last
);
    import sfq_pkg::*;

    localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EX_RD = 3'd1;  // expire walk, address phase
    localparam logic [2:0] S_EX_EV = 3'd2;  // expire walk, age compare
    localparam logic [2:0] S_FC_RD = 3'd3;  // flush count walk, address phase
    localparam logic [2:0] S_FC_EV = 3'd4;  // flush count walk, mark check
    localparam logic [2:0] S_FL_RD = 3'd5;  // flush send walk, address phase
    localparam logic [2:0] S_FL_EV = 3'd6;  // flush send walk, emit word

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          link_reg, link_next;
    logic [31:0]   drop_reg, drop_next;
    logic [31:0]   expc_reg, expc_next;
    logic [6:0]    cap_reg;
    // walk registers
    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] walk_reg, walk_next;
    logic [CW-1:0] tally_reg, tally_next;
    logic [6:0]    num_reg, num_next;     // events the flush will send
    logic [6:0]    sent_reg, sent_next;
    logic [6:0]    slim_reg, slim_next;
    logic [31:0]   now_reg, now_next;
    logic [31:0]   alim_reg, alim_next;

    // output word register
    logic          m_valid_next;
    logic [1:0]    m_status_next;
    logic          m_event_valid_next;
    logic [23:0]   m_sent_point_next;
    logic [15:0]   m_sent_source_next;
    logic [63:0]   m_sent_value_next;
    logic [31:0]   m_sent_stamp_next;
    logic [6:0]    m_tally_next;
    logic [6:0]    m_queue_level_next;
    logic          m_link_up_next;
    logic [31:0]   m_dropped_total_next;
    logic [31:0]   m_expired_total_next;
    logic          m_last_next;

    // store ports
    logic          st_wr_en;
    entry_t        st_wr_entry;
    logic          mk_wr_en;
    logic [AW-1:0] mk_addr;
    logic          mk_data;
    entry_t        rd_entry;
    logic          rd_mark;

    // control of the word load
    logic          ld;
    logic          ld_ev;
    logic [1:0]    o_status;
    logic [6:0]    o_tally;
    logic          o_last;

    logic          out_free;
    logic [CMPW-1:0] cap_eff;
    logic [6:0]    slim_in;
    logic [31:0]   age;
    logic [32:0]   exp_sum;

    sfq_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (st_wr_en),
        .wr_addr  (tail_reg),
        .wr_entry (st_wr_entry),
        .mk_wr_en (mk_wr_en),
        .mk_addr  (mk_addr),
        .mk_data  (mk_data),
        .rd_addr  (pos_reg),
        .rd_entry (rd_entry),
        .rd_mark  (rd_mark)
    );

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
        logic [AW-1:0] r;
        if (i == AW'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + AW'(1);
        end
        return r;
    endfunction

    // the word register may take a new word when empty or being drained
    assign out_free = !m_valid || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;

    // capacity above the store depth acts as the depth
    assign cap_eff = (CMPW'(cap_reg) > CMPW'(QUEUE_DEPTH)) ? CMPW'(QUEUE_DEPTH)
                                                            : CMPW'(cap_reg);
    assign slim_in = (s_send_limit > SEND_CAP) ? SEND_CAP : s_send_limit;
    // age modulo 2^32, used by the age compare of the expire walk
    assign age     = now_reg - rd_entry.stamp;
    assign exp_sum = {1'b0, expc_reg} + 33'(tally_reg);

    assign st_wr_entry.point  = s_point_ident;
    assign st_wr_entry.source = s_source_ident;
    assign st_wr_entry.value  = s_sample_value;
    assign st_wr_entry.stamp  = s_current_time;

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        link_next  = link_reg;
        drop_next  = drop_reg;
        expc_next  = expc_reg;
        pos_next   = pos_reg;
        walk_next  = walk_reg;
        tally_next = tally_reg;
        num_next   = num_reg;
        sent_next  = sent_reg;
        slim_next  = slim_reg;
        now_next   = now_reg;
        alim_next  = alim_reg;

        st_wr_en = 1'b0;
        mk_wr_en = 1'b0;
        mk_addr  = tail_reg;
        mk_data  = 1'b0;

        ld       = 1'b0;
        ld_ev    = 1'b0;
        o_status = ST_OK;
        o_tally  = 7'd0;
        o_last   = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    case (s_action)
                        ACT_ENQUEUE: begin
                            ld = 1'b1;
                            if (CMPW'(count_reg) >= cap_eff) begin
                                // full: drop and count, saturating
                                if (drop_reg != 32'hFFFF_FFFF) begin
                                    drop_next = drop_reg + 32'd1;
                                end
                                o_status = ST_DROPPED;
                            end else begin
                                st_wr_en   = 1'b1;
                                mk_wr_en   = 1'b1;
                                mk_addr    = tail_reg;
                                mk_data    = 1'b0;
                                tail_next  = next_slot(tail_reg);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_FLUSH: begin
                            if (slim_in == 7'd0) begin
                                ld = 1'b1;
                            end else if (!link_reg) begin
                                ld       = 1'b1;
                                o_status = ST_LINK_DOWN;
                            end else begin
                                slim_next  = slim_in;
                                pos_next   = head_reg;
                                walk_next  = '0;
                                num_next   = 7'd0;
                                state_next = S_FC_RD;
                            end
                        end
                        ACT_EXPIRE: begin
                            now_next   = s_current_time;
                            alim_next  = s_age_limit;
                            pos_next   = head_reg;
                            walk_next  = '0;
                            tally_next = '0;
                            state_next = S_EX_RD;
                        end
                        ACT_LINK_UP: begin
                            ld        = 1'b1;
                            link_next = 1'b1;
                        end
                        ACT_LINK_DOWN: begin
                            ld        = 1'b1;
                            link_next = 1'b0;
                        end
                        ACT_CLEAR: begin
                            ld        = 1'b1;
                            drop_next = '0;
                            expc_next = '0;
                        end
                        default: begin
                            ld = 1'b1;
                        end
                    endcase
                end
            end
            S_EX_RD: begin
                if (walk_reg == count_reg) begin
                    // walk done: fold the tally into the saturating total
                    if (out_free) begin
                        expc_next  = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
                        ld         = 1'b1;
                        o_tally    = 7'(tally_reg);
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_EX_EV;
                end
            end
            S_EX_EV: begin
                if (!rd_mark && (age > alim_reg)) begin
                    mk_wr_en   = 1'b1;
                    mk_addr    = pos_reg;
                    mk_data    = 1'b1;
                    tally_next = tally_reg + CW'(1);
                end
                pos_next   = next_slot(pos_reg);
                walk_next  = walk_reg + CW'(1);
                state_next = S_EX_RD;
            end
            S_FC_RD: begin
                if ((walk_reg == count_reg) || (num_reg == slim_reg)) begin
                    // pops are known now: commit head and level before sending
                    if (num_reg == 7'd0) begin
                        if (out_free) begin
                            head_next  = pos_reg;
                            count_next = count_reg - walk_reg;
                            ld         = 1'b1;
                            state_next = S_IDLE;
                        end
                    end else begin
                        head_next  = pos_reg;
                        count_next = count_reg - walk_reg;
                        pos_next   = head_reg;
                        sent_next  = 7'd0;
                        state_next = S_FL_RD;
                    end
                end else begin
                    state_next = S_FC_EV;
                end
            end
            S_FC_EV: begin
                if (!rd_mark) begin
                    num_next = num_reg + 7'd1;
                end
                pos_next   = next_slot(pos_reg);
                walk_next  = walk_reg + CW'(1);
                state_next = S_FC_RD;
            end
            S_FL_RD: begin
                state_next = S_FL_EV;
            end
            S_FL_EV: begin
                if (rd_mark) begin
                    // expired entry leaves silently
                    pos_next   = next_slot(pos_reg);
                    state_next = S_FL_RD;
                end else if (out_free) begin
                    ld        = 1'b1;
                    ld_ev     = 1'b1;
                    o_tally   = num_reg;
                    o_last    = (7'(sent_reg + 7'd1) == num_reg);
                    pos_next  = next_slot(pos_reg);
                    sent_next = sent_reg + 7'd1;
                    if (7'(sent_reg + 7'd1) == num_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_FL_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word, loaded with the state as it stands after the action
    always_comb begin
        m_valid_next         = m_valid && !m_ready;
        m_status_next        = m_status;
        m_event_valid_next   = m_event_valid;
        m_sent_point_next    = m_sent_point;
        m_sent_source_next   = m_sent_source;
        m_sent_value_next    = m_sent_value;
        m_sent_stamp_next    = m_sent_stamp;
        m_tally_next         = m_tally;
        m_queue_level_next   = m_queue_level;
        m_link_up_next       = m_link_up;
        m_dropped_total_next = m_dropped_total;
        m_expired_total_next = m_expired_total;
        m_last_next          = m_last;
        if (ld) begin
            m_valid_next         = 1'b1;
            m_status_next        = o_status;
            m_event_valid_next   = ld_ev;
            m_sent_point_next    = ld_ev ? rd_entry.point  : 24'd0;
            m_sent_source_next   = ld_ev ? rd_entry.source : 16'd0;
            m_sent_value_next    = ld_ev ? rd_entry.value  : 64'd0;
            m_sent_stamp_next    = ld_ev ? rd_entry.stamp  : 32'd0;
            m_tally_next         = o_tally;
            m_queue_level_next   = 7'(count_next);
            m_link_up_next       = link_next;
            m_dropped_total_next = drop_next;
            m_expired_total_next = expc_next;
            m_last_next          = o_last;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            link_reg  <= 1'b1;
            drop_reg  <= '0;
            expc_reg  <= '0;
            cap_reg   <= 7'd64;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            link_reg  <= link_next;
            drop_reg  <= drop_next;
            expc_reg  <= expc_next;
            m_valid   <= m_valid_next;
            if (cfg_wen) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // walk and payload registers, no reset needed
    always_ff @(posedge aclk) begin
        pos_reg         <= pos_next;
        walk_reg        <= walk_next;
        tally_reg       <= tally_next;
        num_reg         <= num_next;
        sent_reg        <= sent_next;
        slim_reg        <= slim_next;
        now_reg         <= now_next;
        alim_reg        <= alim_next;
        m_status        <= m_status_next;
        m_event_valid   <= m_event_valid_next;
        m_sent_point    <= m_sent_point_next;
        m_sent_source   <= m_sent_source_next;
        m_sent_value    <= m_sent_value_next;
        m_sent_stamp    <= m_sent_stamp_next;
        m_tally         <= m_tally_next;
        m_queue_level   <= m_queue_level_next;
        m_link_up       <= m_link_up_next;
        m_dropped_total <= m_dropped_total_next;
        m_expired_total <= m_expired_total_next;
        m_last          <= m_last_next;
    end

endmodule
